FILE: design/cqd_pkg.sv
// Shared types, constants and factor tables of the coefficient quantizer.
package cqd_pkg;

    localparam int COEFF_IN_W    = 16;
    localparam int COEFF_OUT_W   = 17;
    localparam int INDEX_W       = 13;
    localparam int GROUP_IDX_W   = 5;
    localparam int QSTEP_W       = 7;
    localparam int GWIDTH_W      = 9;
    localparam int SHIFT_W       = 4;
    localparam int LEVEL_W       = 3;
    localparam int CLASS_W       = 3;
    localparam int RESCALE_W     = 7;
    localparam int DESCALE_W     = 15;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 9;

    localparam int NUM_GROUPS    = 16;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 13'd8191;

    localparam int QUANT_FRAC    = 14;
    localparam int QUANT_ROUND   = 8192;
    localparam int DEQ_FRAC      = 4;

    localparam logic OP_QUANT    = 1'b0;
    localparam logic OP_DEQUANT  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_QUANT_STEP  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_WIDTH = 1'd1;

    typedef struct packed {
        logic                         opcode;
        logic signed [COEFF_IN_W-1:0] coeff_in;
        logic                         is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [COEFF_OUT_W-1:0] coeff_out;
        logic                          last_out;
        logic [INDEX_W-1:0]            used_count;
        logic                          past_end;
    } t_out_item;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } t_cfg_write;

    // Operands for the arithmetic stage.
    typedef struct packed {
        logic                         opcode;
        logic signed [COEFF_IN_W-1:0] x;
        logic [SHIFT_W-1:0]           shift;
        logic [RESCALE_W-1:0]         rescale;
        logic [DESCALE_W-1:0]         descale;
        logic                         beyond;
    } t_arith_req;

    // Product class of the table position that group g maps to through the scan.
    function automatic logic [CLASS_W-1:0] group_class(input logic [3:0] g);
        logic [CLASS_W-1:0] c;
        case (g)
            4'd0:    c = 3'd0;
            4'd1:    c = 3'd1;
            4'd2:    c = 3'd1;
            4'd3:    c = 3'd0;
            4'd4:    c = 3'd3;
            4'd5:    c = 3'd0;
            4'd6:    c = 3'd2;
            4'd7:    c = 3'd1;
            4'd8:    c = 3'd1;
            4'd9:    c = 3'd2;
            4'd10:   c = 3'd4;
            4'd11:   c = 3'd0;
            4'd12:   c = 3'd4;
            4'd13:   c = 3'd2;
            4'd14:   c = 3'd2;
            default: c = 3'd5;
        endcase
        return c;
    endfunction

    function automatic logic [RESCALE_W-1:0] rescale_of(input logic [LEVEL_W-1:0] level,
                                                        input logic [CLASS_W-1:0] cls);
        logic [RESCALE_W-1:0] r;
        r = 7'd0;
        case (level)
            3'd0: case (cls)
                3'd0: r = 7'd16; 3'd1: r = 7'd21; 3'd2: r = 7'd24;
                3'd3: r = 7'd28; 3'd4: r = 7'd32; default: r = 7'd37;
            endcase
            3'd1: case (cls)
                3'd0: r = 7'd17; 3'd1: r = 7'd23; 3'd2: r = 7'd26;
                3'd3: r = 7'd31; 3'd4: r = 7'd35; default: r = 7'd40;
            endcase
            3'd2: case (cls)
                3'd0: r = 7'd19; 3'd1: r = 7'd25; 3'd2: r = 7'd29;
                3'd3: r = 7'd33; 3'd4: r = 7'd38; default: r = 7'd43;
            endcase
            3'd3: case (cls)
                3'd0: r = 7'd21; 3'd1: r = 7'd28; 3'd2: r = 7'd31;
                3'd3: r = 7'd36; 3'd4: r = 7'd42; default: r = 7'd47;
            endcase
            3'd4: case (cls)
                3'd0: r = 7'd23; 3'd1: r = 7'd30; 3'd2: r = 7'd34;
                3'd3: r = 7'd40; 3'd4: r = 7'd45; default: r = 7'd52;
            endcase
            3'd5: case (cls)
                3'd0: r = 7'd25; 3'd1: r = 7'd33; 3'd2: r = 7'd37;
                3'd3: r = 7'd43; 3'd4: r = 7'd49; default: r = 7'd56;
            endcase
            3'd6: case (cls)
                3'd0: r = 7'd27; 3'd1: r = 7'd36; 3'd2: r = 7'd41;
                3'd3: r = 7'd47; 3'd4: r = 7'd54; default: r = 7'd61;
            endcase
            default: case (cls)
                3'd0: r = 7'd29; 3'd1: r = 7'd39; 3'd2: r = 7'd44;
                3'd3: r = 7'd52; 3'd4: r = 7'd59; default: r = 7'd67;
            endcase
        endcase
        return r;
    endfunction

    // Descale factor floor((524288 + r) / (2r)) for every rescale value in the table.
    function automatic logic [DESCALE_W-1:0] descale_of(input logic [RESCALE_W-1:0] r);
        logic [DESCALE_W-1:0] f;
        case (r)
            7'd16:   f = 15'd16384;
            7'd17:   f = 15'd15420;
            7'd19:   f = 15'd13797;
            7'd21:   f = 15'd12483;
            7'd23:   f = 15'd11398;
            7'd24:   f = 15'd10923;
            7'd25:   f = 15'd10486;
            7'd26:   f = 15'd10082;
            7'd27:   f = 15'd9709;
            7'd28:   f = 15'd9362;
            7'd29:   f = 15'd9039;
            7'd30:   f = 15'd8738;
            7'd31:   f = 15'd8456;
            7'd32:   f = 15'd8192;
            7'd33:   f = 15'd7944;
            7'd34:   f = 15'd7710;
            7'd35:   f = 15'd7490;
            7'd36:   f = 15'd7282;
            7'd37:   f = 15'd7085;
            7'd38:   f = 15'd6899;
            7'd39:   f = 15'd6722;
            7'd40:   f = 15'd6554;
            7'd41:   f = 15'd6394;
            7'd42:   f = 15'd6242;
            7'd43:   f = 15'd6096;
            7'd44:   f = 15'd5958;
            7'd45:   f = 15'd5825;
            7'd47:   f = 15'd5578;
            7'd49:   f = 15'd5350;
            7'd52:   f = 15'd5041;
            7'd54:   f = 15'd4855;
            7'd56:   f = 15'd4681;
            7'd59:   f = 15'd4443;
            7'd61:   f = 15'd4297;
            7'd67:   f = 15'd3913;
            default: f = 15'd0;
        endcase
        return f;
    endfunction

endpackage

FILE: design/cqd_chan_if.sv
// Valid/ready channel interface carrying one payload of a given type.
interface cqd_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/cqd_arith.sv
// Quantize / dequantize / pass-through arithmetic for one coefficient.
module cqd_arith (
    input  cqd_pkg::t_arith_req                    i_req,
    output logic signed [cqd_pkg::COEFF_OUT_W-1:0] o_coeff
);
    import cqd_pkg::*;

    localparam int QPROD_W = 32;
    localparam int QSUM_W  = 19;
    localparam int DPROD_W = COEFF_IN_W + RESCALE_W + 1;

    logic signed [QPROD_W-1:0]    q_prod;
    logic signed [QPROD_W-1:0]    q_round;
    logic signed [QSUM_W-1:0]     q_p;
    logic signed [QSUM_W-1:0]     q_scale;
    logic signed [QSUM_W-1:0]     q_bias;
    logic signed [QSUM_W-1:0]     q_adj;
    logic signed [QSUM_W-1:0]     q_sum;
    logic signed [QSUM_W-1:0]     q_res;
    logic signed [DPROD_W-1:0]    d_prod;
    logic signed [DPROD_W-1:0]    d_right;
    logic [2:0]                   d_rsh;
    logic [SHIFT_W-1:0]           d_lsh;
    logic [COEFF_IN_W-1:0]        d_word;

    always_comb begin
        // quantize: round the 14-bit fixed-point product, then deadzone and shift
        q_prod  = QPROD_W'(i_req.x) * QPROD_W'($signed({1'b0, i_req.descale}));
        q_round = q_prod + QPROD_W'(QUANT_ROUND);
        q_p     = QSUM_W'(q_round >>> QUANT_FRAC);
        q_scale = QSUM_W'(1) << i_req.shift;
        q_bias  = (q_scale >>> 1) - (q_scale >>> 4);
        q_adj   = q_p[QSUM_W-1] ? (q_scale - QSUM_W'(1) - q_bias) : q_bias;
        q_sum   = q_p + q_adj;
        q_res   = q_sum >>> i_req.shift;

        // dequantize: scale by the rescale factor, shift by shift - 4, wrap to 16 bits
        d_prod  = DPROD_W'(i_req.x) * DPROD_W'($signed({1'b0, i_req.rescale}));
        d_rsh   = 3'(DEQ_FRAC) - {1'b0, i_req.shift[1:0]};
        d_lsh   = i_req.shift - SHIFT_W'(DEQ_FRAC);
        d_right = d_prod >>> d_rsh;
        if (i_req.shift < SHIFT_W'(DEQ_FRAC)) begin
            d_word = d_right[COEFF_IN_W-1:0];
        end else begin
            d_word = d_prod[COEFF_IN_W-1:0] << d_lsh;
        end

        if (i_req.beyond) begin
            o_coeff = COEFF_OUT_W'(i_req.x);
        end else if (i_req.opcode == OP_DEQUANT) begin
            o_coeff = COEFF_OUT_W'($signed(d_word));
        end else begin
            o_coeff = q_res[COEFF_OUT_W-1:0];
        end
    end
endmodule

FILE: design/coefficient_quantizer_dequantizer.sv
// Top level: subband deadzone quantizer / dequantizer with position tracking.
//
//  channel  dir  payload                                        handshake
//  i_in     in   opcode, coeff_in, is_last                      valid/ready
//  o_out    out  coeff_out, last_out, used_count, past_end      valid/ready
//  i_cfg    in   index (0 quant_step, 1 group_width), value     valid/ready, ready always 1
//
// One request per cycle sustained while o_out is not stalled; each is registered in turn:
// the entry stage looks up the group factor, the result stage does the multiply,
// round and shift. The result register decouples the sides, so a new request is taken
// while a result waits; a stalled output backs up the entry stage and then i_in.ready.
// Synchronous active-low reset clears the valid bits, the position counters and the
// registers (quant_step 0, group_width 1); there is no clearing pass.
module coefficient_quantizer_dequantizer #(
    parameter int MAX_GROUP_WIDTH = 256
) (
    input logic         i_clk,
    input logic         i_rst_n,
    cqd_chan_if.sink    i_in,
    cqd_chan_if.source  o_out,
    cqd_chan_if.sink    i_cfg
);
    import cqd_pkg::*;

    localparam int POS_W = (MAX_GROUP_WIDTH > 1) ? $clog2(MAX_GROUP_WIDTH) : 1;
    localparam int CMP_W = (POS_W + 1 > GWIDTH_W) ? POS_W + 1 : GWIDTH_W;

    typedef struct packed {
        t_arith_req         req;
        logic               last;
        logic [INDEX_W-1:0] ext;
    } t_stage1;

    // configuration
    logic [QSTEP_W-1:0]     r_quant_step;
    logic [GWIDTH_W-1:0]    r_group_width;

    // block position state
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [GROUP_IDX_W-1:0] r_group, n_group;
    logic [INDEX_W-1:0]     r_item, n_item;
    logic [INDEX_W-1:0]     r_nz, n_nz;

    // pipeline
    logic                   r_s1_valid;
    t_stage1                r_s1, n_s1;
    logic                   r_s2_valid;
    t_out_item              r_s2, n_s2;

    logic                   in_fire;
    logic                   s2_free;
    logic                   s1_adv;
    logic                   beyond;
    logic [CMP_W-1:0]       width_eff;
    logic [CMP_W-1:0]       pos_inc;
    logic [RESCALE_W-1:0]   rescale;
    logic signed [COEFF_OUT_W-1:0] arith_y;

    assign s2_free    = !r_s2_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && s2_free;
    assign i_in.ready = !r_s1_valid || s2_free;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid = r_s2_valid;
    assign o_out.data  = r_s2;

    // Entry stage: pick the factor of the current group and advance position, clearing it at block end.
    always_comb begin
        beyond  = r_group >= GROUP_IDX_W'(NUM_GROUPS);
        rescale = rescale_of(r_quant_step[LEVEL_W-1:0], group_class(r_group[3:0]));

        // zero width acts as one, wide width saturates
        width_eff = CMP_W'(r_group_width);
        if (r_group_width == '0) begin
            width_eff = CMP_W'(1);
        end else if (width_eff > CMP_W'(MAX_GROUP_WIDTH)) begin
            width_eff = CMP_W'(MAX_GROUP_WIDTH);
        end
        pos_inc = CMP_W'(r_pos) + CMP_W'(1);

        n_s1.req.opcode  = i_in.data.opcode;
        n_s1.req.x       = i_in.data.coeff_in;
        n_s1.req.shift   = r_quant_step[QSTEP_W-1:LEVEL_W];
        n_s1.req.rescale = rescale;
        n_s1.req.descale = descale_of(rescale);
        n_s1.req.beyond  = beyond;
        n_s1.last        = i_in.data.is_last;
        n_s1.ext         = (r_item < INDEX_MAX) ? r_item + INDEX_W'(1) : INDEX_MAX;

        n_pos   = r_pos;
        n_group = r_group;
        n_item  = r_item;
        if (in_fire) begin
            if (i_in.data.is_last) begin
                n_pos   = '0;
                n_group = '0;
                n_item  = '0;
            end else begin
                if (r_item < INDEX_MAX) begin
                    n_item = r_item + INDEX_W'(1);
                end
                if (!beyond) begin
                    if (pos_inc >= width_eff) begin
                        n_pos   = '0;
                        n_group = r_group + GROUP_IDX_W'(1);
                    end else begin
                        n_pos = pos_inc[POS_W-1:0];
                    end
                end
            end
        end
    end

    cqd_arith u_arith (
        .i_req   (r_s1.req),
        .o_coeff (arith_y)
    );

    // Result stage: extend the nonzero run and drop it at block end.
    always_comb begin
        n_s2.coeff_out  = arith_y;
        n_s2.last_out   = r_s1.last;
        n_s2.used_count = (arith_y != '0) ? r_s1.ext : r_nz;
        n_s2.past_end   = r_s1.req.beyond;

        n_nz = r_nz;
        if (s1_adv) begin
            n_nz = r_s1.last ? '0 : n_s2.used_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_step  <= '0;
            r_group_width <= GWIDTH_W'(1);
            r_pos         <= '0;
            r_group       <= '0;
            r_item        <= '0;
            r_nz          <= '0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    REG_QUANT_STEP:  r_quant_step  <= i_cfg.data.value[QSTEP_W-1:0];
                    REG_GROUP_WIDTH: r_group_width <= i_cfg.data.value[GWIDTH_W-1:0];
                    default: ;
                endcase
            end
            r_pos   <= n_pos;
            r_group <= n_group;
            r_item  <= n_item;
            r_nz    <= n_nz;

            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_s2 <= n_s2;
        end
    end

    a_last_clears_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.data.is_last) |=> (r_pos == '0 && r_group == '0 && r_item == '0))
        else $error("position state not cleared after block end");

    a_beyond_holds_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && beyond && !i_in.data.is_last) |=> ($stable(r_group) && $stable(r_pos)))
        else $error("group advanced past the last group");

    a_beyond_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1.req.beyond) |=>
        (r_s2.past_end && r_s2.coeff_out == COEFF_OUT_W'($past(r_s1.req.x))))
        else $error("coefficient beyond the groups not passed unchanged");

    a_nonzero_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.coeff_out != '0) |-> (r_s2.used_count != '0))
        else $error("nonzero result with zero used count");

endmodule

FILE: dv/cqd_checker.sv
// Checker: predicts each coefficient result and compares it with the block's output.
module cqd_checker #(
    parameter int MAX_GROUP_WIDTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  cqd_pkg::t_in_item   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  cqd_pkg::t_out_item  i_out_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  cqd_pkg::t_cfg_write i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cqd_pkg::*;

    // zigzag scan: group g reads table position SCAN_POS[g]
    localparam int SCAN_POS [16] = '{0, 4, 1, 2, 5, 8, 12, 9, 6, 3, 7, 10, 13, 14, 11, 15};
    // norm product class of table position y*4+x
    localparam int NORM_CLASS [16] = '{0, 1, 0, 2, 1, 3, 1, 4, 0, 1, 0, 2, 2, 4, 2, 5};
    localparam int LEVEL_RESCALE [8][6] = '{
        '{16, 21, 24, 28, 32, 37},
        '{17, 23, 26, 31, 35, 40},
        '{19, 25, 29, 33, 38, 43},
        '{21, 28, 31, 36, 42, 47},
        '{23, 30, 34, 40, 45, 52},
        '{25, 33, 37, 43, 49, 56},
        '{27, 36, 41, 47, 54, 61},
        '{29, 39, 44, 52, 59, 67}
    };

    logic [QSTEP_W-1:0]  qstep_r;
    logic [GWIDTH_W-1:0] gwidth_r;
    int                  pos_cnt;
    int                  group_cnt;
    int                  coeff_idx;
    int                  extent;
    int                  fail_total;
    t_out_item           pending_coeffs [$];
    t_out_item           want;

    function automatic t_out_item predict_coeff(input t_in_item item);
        t_out_item   res;
        int          width;
        int          shift;
        int          level;
        bit          beyond;
        longint      x;
        longint      r;
        longint      f;
        longint      p;
        longint      scale;
        longint      bias;
        longint      prod;
        longint      y;
        logic [15:0] wrapped;
        shift  = int'(qstep_r[6:3]);
        level  = int'(qstep_r[2:0]);
        width  = int'(gwidth_r);
        if (width == 0)
            width = 1;
        if (width > MAX_GROUP_WIDTH)
            width = MAX_GROUP_WIDTH;
        beyond = (group_cnt >= NUM_GROUPS);
        x      = longint'(item.coeff_in);

        if (beyond) begin
            y = x;
        end else begin
            r = LEVEL_RESCALE[level][NORM_CLASS[SCAN_POS[group_cnt]]];
            if (item.opcode == OP_QUANT) begin
                f     = (524288 + r) / (2 * r);
                p     = (x * f + 8192) >>> 14;
                scale = longint'(1) << shift;
                bias  = (scale >>> 1) - (scale >>> 4);
                if (p >= 0)
                    p = p + bias;
                else
                    p = p + scale - 1 - bias;
                y = p >>> shift;
            end else begin
                prod = x * r;
                if (shift < 4)
                    wrapped = 16'(prod >>> (4 - shift));
                else
                    wrapped = 16'(prod << (shift - 4));
                y = longint'($signed(wrapped));
            end
        end

        if (y != 0)
            extent = (coeff_idx < int'(INDEX_MAX)) ? coeff_idx + 1 : int'(INDEX_MAX);

        res.coeff_out  = y[COEFF_OUT_W-1:0];
        res.last_out   = item.is_last;
        res.used_count = extent[INDEX_W-1:0];
        res.past_end   = beyond;

        if (item.is_last) begin
            pos_cnt   = 0;
            group_cnt = 0;
            coeff_idx = 0;
            extent    = 0;
        end else begin
            if (coeff_idx < int'(INDEX_MAX))
                coeff_idx++;
            if (!beyond) begin
                if (pos_cnt + 1 >= width) begin
                    pos_cnt = 0;
                    group_cnt++;
                end else begin
                    pos_cnt++;
                end
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(input string field, input longint exp_v, input longint got_v);
        fail_total++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            qstep_r    = '0;
            gwidth_r   = GWIDTH_W'(1);
            pos_cnt    = 0;
            group_cnt  = 0;
            coeff_idx  = 0;
            extent     = 0;
            fail_total = 0;
            pending_coeffs.delete();
        end else begin
            // retire first: a result can never belong to a request taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (pending_coeffs.size() == 0) begin
                    note_mismatch("unexpected result, coeff_out", 0,
                                  longint'(i_out_data.coeff_out));
                end else begin
                    want = pending_coeffs.pop_front();
                    if (i_out_data.coeff_out !== want.coeff_out)
                        note_mismatch("coeff_out", longint'(want.coeff_out),
                                      longint'(i_out_data.coeff_out));
                    if (i_out_data.last_out !== want.last_out)
                        note_mismatch("last_out", longint'(want.last_out),
                                      longint'(i_out_data.last_out));
                    if (i_out_data.used_count !== want.used_count)
                        note_mismatch("used_count", longint'(want.used_count),
                                      longint'(i_out_data.used_count));
                    if (i_out_data.past_end !== want.past_end)
                        note_mismatch("past_end", longint'(want.past_end),
                                      longint'(i_out_data.past_end));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_data.index == REG_QUANT_STEP)
                    qstep_r = i_cfg_data.value[QSTEP_W-1:0];
                else
                    gwidth_r = i_cfg_data.value;
            end
            if (i_in_valid && i_in_ready)
                pending_coeffs.push_back(predict_coeff(i_in_data));
        end
        o_pending    <= pending_coeffs.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: dv/tb.sv
// Testbench top: drives coefficient requests and register writes, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cqd_pkg::*;

    localparam int MAX_GW            = 256;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int ITEMS_PER_SETTING = 58;
    localparam int NUM_SETTINGS      = 6;
    // two pipeline stages plus margin
    localparam int SETTLE_CYCLES     = 6;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    cqd_chan_if #(.t_payload(t_in_item))   in_if  ();
    cqd_chan_if #(.t_payload(t_out_item))  out_if ();
    cqd_chan_if #(.t_payload(t_cfg_write)) cfg_if ();

    coefficient_quantizer_dequantizer #(
        .MAX_GROUP_WIDTH (MAX_GW)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    cqd_checker #(
        .MAX_GROUP_WIDTH (MAX_GW)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_in_data    (in_if.data),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_data   (out_if.data),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_data   (cfg_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: end the run as failed when the cycle counter reaches its limit, progress or not.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: stall at the rate of the current phase, redrawn every cycle.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Present one request and hold it until accepted. The idle gap only lowers valid in
    // cycles before the new request, so valid is never lowered and raised in one step.
    task automatic send_coeff(input logic op, input logic signed [COEFF_IN_W-1:0] x,
                              input logic last);
        t_in_item item;
        item.opcode   = op;
        item.coeff_in = x;
        item.is_last  = last;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= item;
        do @(posedge clk); while (!in_if.ready);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; valid stays high across the two writes.
    task automatic configure(input logic [CFG_DATA_W-1:0] qstep,
                             input logic [CFG_DATA_W-1:0] gwidth);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: REG_QUANT_STEP, value: qstep};
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.data  <= '{index: REG_GROUP_WIDTH, value: gwidth};
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Mix of extremes, near-zero values (which can quantize to zero) and full-range noise.
    function automatic logic signed [COEFF_IN_W-1:0] pick_coeff();
        logic signed [COEFF_IN_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 16'sh7FFF;
            1:       v = 16'sh8000;
            2, 3, 4: v = COEFF_IN_W'($signed($urandom_range(40)) - 20);
            5:       v = '0;
            default: v = COEFF_IN_W'($urandom());
        endcase
        return v;
    endfunction

    // Whole blocks closed by is_last, long enough to run past the sixteen groups for
    // narrow widths; one in ten is short, one to three items. A block left open at the end spans the
    // next register write.
    task automatic send_random_blocks(input int n_items, input int eff_width);
        int sent;
        int len;
        int upper;
        sent = 0;
        while (sent < n_items) begin
            upper = eff_width * NUM_GROUPS + 6;
            if (upper > 60)
                upper = 60;
            if ($urandom_range(9) == 0)
                len = $urandom_range(3, 1);
            else
                len = $urandom_range(upper, 1);
            for (int i = 0; i < len && sent < n_items; i++) begin
                send_coeff(1'($urandom_range(1)), pick_coeff(), (i == len - 1));
                sent++;
            end
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] qstep;
        logic [CFG_DATA_W-1:0] gwidth;
        int                    eff_width;

        rst_n        <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset settings first (quant_step 0, width 1): one group
        // per request, so the sixteen groups run out after sixteen requests.
        send_coeff(OP_QUANT,   16'sh7FFF, 1'b0);
        send_coeff(OP_QUANT,   16'sh8000, 1'b0);
        send_coeff(OP_QUANT,   16'sd0,    1'b0);
        send_coeff(OP_QUANT,   16'sd1,    1'b0);
        send_coeff(OP_QUANT,   -16'sd1,   1'b0);
        send_coeff(OP_DEQUANT, 16'sh7FFF, 1'b0);
        send_coeff(OP_DEQUANT, 16'sh8000, 1'b0);
        send_coeff(OP_DEQUANT, 16'sd0,    1'b0);
        send_coeff(OP_DEQUANT, 16'sd1,    1'b0);
        send_coeff(OP_DEQUANT, -16'sd1,   1'b0);
        send_coeff(OP_QUANT,   16'sd100,  1'b0);
        send_coeff(OP_QUANT,   -16'sd100, 1'b0);
        send_coeff(OP_DEQUANT, 16'sd100,  1'b0);
        send_coeff(OP_DEQUANT, -16'sd100, 1'b0);
        send_coeff(OP_QUANT,   16'sd5,    1'b0);
        send_coeff(OP_DEQUANT, -16'sd5,   1'b0);
        // past the last group: pass through unchanged
        send_coeff(OP_QUANT,   16'sh8000, 1'b0);
        send_coeff(OP_DEQUANT, 16'sh7FFF, 1'b0);
        send_coeff(OP_QUANT,   16'sd0,    1'b1);
        drain_results();

        // Largest step with zero width, which must act as width one.
        configure(CFG_DATA_W'(127), CFG_DATA_W'(0));
        send_coeff(OP_QUANT,   16'sh8000, 1'b0);
        send_coeff(OP_QUANT,   16'sh7FFF, 1'b0);
        send_coeff(OP_DEQUANT, 16'sh8000, 1'b0);
        send_coeff(OP_DEQUANT, 16'sh7FFF, 1'b1);

        // Random part: four handshake pressure phases, several register settings in each.
        for (int ph = 0; ph < 4; ph++) begin
            for (int st = 0; st < NUM_SETTINGS; st++) begin
                drain_results();
                case (ph)
                    0: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                    end
                    1: begin
                        send_idle_pct  = 46;
                        recv_stall_pct = 0;
                    end
                    2: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 46;
                    end
                    default: begin
                        send_idle_pct  = 28;
                        recv_stall_pct = 28;
                    end
                endcase
                case (st)
                    0: begin
                        qstep  = CFG_DATA_W'(0);
                        gwidth = CFG_DATA_W'(1);
                    end
                    1: begin
                        qstep  = CFG_DATA_W'(127);
                        gwidth = CFG_DATA_W'($urandom_range(3, 2));
                    end
                    2: begin
                        // upper value bits beyond the register width are junk
                        qstep  = CFG_DATA_W'($urandom_range(511));
                        gwidth = CFG_DATA_W'(0);
                    end
                    3: begin
                        // above the maximum: saturates to the maximum width
                        qstep  = CFG_DATA_W'($urandom_range(127));
                        gwidth = CFG_DATA_W'($urandom_range(511, MAX_GW + 1));
                    end
                    4: begin
                        qstep  = CFG_DATA_W'($urandom_range(127));
                        gwidth = CFG_DATA_W'($urandom_range(4, 1));
                    end
                    default: begin
                        qstep  = CFG_DATA_W'($urandom_range(127));
                        gwidth = CFG_DATA_W'(MAX_GW);
                    end
                endcase
                configure(qstep, gwidth);
                eff_width = int'(gwidth);
                if (eff_width == 0)
                    eff_width = 1;
                if (eff_width > MAX_GW)
                    eff_width = MAX_GW;
                send_random_blocks(ITEMS_PER_SETTING, eff_width);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/cqd_pkg.sv
design/cqd_chan_if.sv
design/cqd_arith.sv
design/coefficient_quantizer_dequantizer.sv
dv/cqd_checker.sv
dv/tb.sv
